/* hw/rtl/kmc_pkg.sv */
// Package for the k-mer histogram counter: field widths, mode codes,
// symbol classification and the structs passed between the block's modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kmc_pkg;

    // Payload widths of the channels
    localparam int MODE_W    = 2;
    localparam int SYMBOL_W  = 8;
    localparam int RDIDX_W   = 8;
    localparam int OUT_CNT_W = 32;

    // Result queue depth (covers the table stage plus one registered result)
    localparam int OUT_DEPTH = 3;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_CNT_FILL_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_FEED    = 2'd0,
        MODE_NEW_SEQ = 2'd1,
        MODE_READ    = 2'd2,
        MODE_NOP     = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        SYM_BASE = 2'd0,
        SYM_SKIP = 2'd1,
        SYM_BAD  = 2'd2
    } t_sym_kind;

    typedef struct packed {
        t_sym_kind  kind;
        logic [1:0] code;
    } t_sym;

    // Request from the front end to the count table
    typedef struct packed {
        logic cnt;   // increment the counter at the address
        logic rd;    // return the counter at the address
        logic err;   // error flag after this transaction
    } t_req;

    // One result transaction
    typedef struct packed {
        logic [OUT_CNT_W-1:0] count;
        logic                 err;
    } t_result;

    // A/T/C/G -> 0/1/2/3 in either case, N/n skipped, anything else bad
    function automatic t_sym classify(input logic [SYMBOL_W-1:0] ch);
        t_sym s;
        s.kind = SYM_BASE;
        s.code = 2'd0;
        unique case (ch)
            8'h41, 8'h61: s.code = 2'd0;
            8'h54, 8'h74: s.code = 2'd1;
            8'h43, 8'h63: s.code = 2'd2;
            8'h47, 8'h67: s.code = 2'd3;
            8'h4E, 8'h6E: s.kind = SYM_SKIP;
            default:      s.kind = SYM_BAD;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/kmc_if.sv */
// Valid/ready channel interfaces of the k-mer histogram counter.
// Depends on kmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface kmc_in_if;
    logic                         valid;
    logic                         ready;
    logic [kmc_pkg::MODE_W-1:0]   mode;
    logic [kmc_pkg::SYMBOL_W-1:0] symbol;
    logic [kmc_pkg::RDIDX_W-1:0]  read_index;

    modport source (output valid, mode, symbol, read_index, input ready);
    modport sink   (input valid, mode, symbol, read_index, output ready);
endinterface

interface kmc_out_if;
    logic                          valid;
    logic                          ready;
    logic [kmc_pkg::OUT_CNT_W-1:0] kmer_count;
    logic                          error_flag;

    modport source (output valid, kmer_count, error_flag, input ready);
    modport sink   (input valid, kmer_count, error_flag, output ready);
endinterface

`default_nettype wire

/* hw/rtl/kmc_front.sv */
// Front end: symbol classification, k-mer window, seen count and error flag.
// Produces the table address and request for each accepted transaction.
// Depends on kmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kmc_front #(
    parameter int K = 4
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_accept,
    input  wire logic [kmc_pkg::MODE_W-1:0]   i_mode,
    input  wire logic [kmc_pkg::SYMBOL_W-1:0] i_symbol,
    input  wire logic [kmc_pkg::RDIDX_W-1:0]  i_read_index,
    output kmc_pkg::t_req                     o_req,
    output logic [2*K-1:0]                    o_addr
);

    localparam int IDX_W  = 2 * K;
    localparam int SEEN_W = $clog2(K + 1);

    logic [IDX_W-1:0]  r_window, n_window;
    logic [SEEN_W-1:0] r_seen, n_seen;
    logic              r_invalid, n_invalid;

    kmc_pkg::t_sym                  sym;
    logic [IDX_W+1:0]               shifted;
    logic [IDX_W+kmc_pkg::RDIDX_W-1:0] idx_ext;
    logic                           cnt;

    assign sym     = kmc_pkg::classify(i_symbol);
    assign shifted = {r_window, sym.code};
    assign idx_ext = {{IDX_W{1'b0}}, i_read_index};

    // Next window state for the transaction
    always_comb begin
        n_window  = r_window;
        n_seen    = r_seen;
        n_invalid = r_invalid;
        cnt       = 1'b0;
        unique case (kmc_pkg::t_mode'(i_mode))
            kmc_pkg::MODE_FEED: begin
                if (!r_invalid) begin
                    unique case (sym.kind)
                        kmc_pkg::SYM_BASE: begin
                            n_window = shifted[IDX_W-1:0];
                            if (r_seen < SEEN_W'(K)) begin
                                n_seen = r_seen + SEEN_W'(1);
                            end
                            cnt = (r_seen >= SEEN_W'(K - 1));
                        end
                        kmc_pkg::SYM_BAD:  n_invalid = 1'b1;
                        default: ;
                    endcase
                end
            end
            kmc_pkg::MODE_NEW_SEQ: begin
                n_window  = '0;
                n_seen    = '0;
                n_invalid = 1'b0;
            end
            default: ;
        endcase
    end

    assign o_req.cnt = cnt;
    assign o_req.rd  = (kmc_pkg::t_mode'(i_mode) == kmc_pkg::MODE_READ);
    assign o_req.err = n_invalid;
    assign o_addr    = cnt ? n_window : idx_ext[IDX_W-1:0];

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window  <= '0;
            r_seen    <= '0;
            r_invalid <= 1'b0;
        end else if (i_accept) begin
            r_window  <= n_window;
            r_seen    <= n_seen;
            r_invalid <= n_invalid;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/kmc_table.sv */
// Count table: synchronous memory with read-modify-write, write forwarding,
// and a clearing sweep after reset. Depends on kmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kmc_table #(
    parameter int K           = 4,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire kmc_pkg::t_req  i_req,
    input  wire logic [2*K-1:0] i_addr,
    output logic                o_busy,
    output logic                o_res_vld,
    output kmc_pkg::t_result    o_res
);

    localparam int IDX_W = 2 * K;
    localparam int DEPTH = 1 << IDX_W;
    localparam int OW    = kmc_pkg::OUT_CNT_W;

    logic [COUNT_WIDTH-1:0] mem [DEPTH];

    logic                   r_clearing;
    logic [IDX_W-1:0]       r_clr_addr;
    logic                   r_s1_vld;
    kmc_pkg::t_req          r_s1_req;
    logic [IDX_W-1:0]       r_s1_addr;
    logic [COUNT_WIDTH-1:0] r_rdata;
    logic                   r_fwd_vld;
    logic [IDX_W-1:0]       r_fwd_addr;
    logic [COUNT_WIDTH-1:0] r_fwd_data;

    logic [COUNT_WIDTH-1:0]    cur;
    logic [COUNT_WIDTH-1:0]    inc;
    logic                      s1_wr;
    logic                      w_en;
    logic [IDX_W-1:0]          w_addr;
    logic [COUNT_WIDTH-1:0]    w_data;
    logic [COUNT_WIDTH+OW-1:0] cnt_ext;

    // Forward the previous write when the read raced it
    assign cur   = (r_fwd_vld && r_fwd_addr == r_s1_addr) ? r_fwd_data : r_rdata;
    assign inc   = (&cur) ? cur : cur + COUNT_WIDTH'(1);
    assign s1_wr = r_s1_vld && r_s1_req.cnt;

    // Write port: clearing sweep or counter update
    assign w_en   = r_clearing || s1_wr;
    assign w_addr = r_clearing ? r_clr_addr : r_s1_addr;
    assign w_data = r_clearing ? '0 : inc;

    assign cnt_ext      = {{OW{1'b0}}, (r_s1_req.rd ? cur : '0)};
    assign o_res.count  = cnt_ext[OW-1:0];
    assign o_res.err    = r_s1_req.err;
    assign o_res_vld    = r_s1_vld;
    assign o_busy       = r_clearing;

    // Memory
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_rdata <= mem[i_addr];
        end
        if (w_en) begin
            mem[w_addr] <= w_data;
        end
    end

    // Stage payload and forwarding data
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_req  <= i_req;
            r_s1_addr <= i_addr;
        end
        if (s1_wr) begin
            r_fwd_addr <= r_s1_addr;
            r_fwd_data <= inc;
        end
    end

    // Control: clearing sweep, stage valid, forward valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_s1_vld   <= 1'b0;
            r_fwd_vld  <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
                if (&r_clr_addr) begin
                    r_clearing <= 1'b0;
                end
            end
            r_s1_vld <= i_accept;
            if (s1_wr) begin
                r_fwd_vld <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/kmc_out_fifo.sv */
// Result queue of three entries driving the output channel.
// Depends on kmc_pkg and kmc_if.
`timescale 1ns / 1ps
`default_nettype none

module kmc_out_fifo (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_push,
    input  wire kmc_pkg::t_result                      i_res,
    output logic [kmc_pkg::OUT_CNT_FILL_W-1:0]         o_fill,
    kmc_out_if.source                                  o_out_ch
);

    localparam int PW = kmc_pkg::OUT_PTR_W;
    localparam int FW = kmc_pkg::OUT_CNT_FILL_W;

    kmc_pkg::t_result r_buf [kmc_pkg::OUT_DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [FW-1:0]    r_fill;
    logic             pop;

    assign pop                 = o_out_ch.valid && o_out_ch.ready;
    assign o_out_ch.valid      = (r_fill != '0);
    assign o_out_ch.kmer_count = r_buf[r_rd_ptr].count;
    assign o_out_ch.error_flag = r_buf[r_rd_ptr].err;
    assign o_fill              = r_fill;

    function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
        return (p == PW'(kmc_pkg::OUT_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_res;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            if (i_push && !pop) begin
                r_fill <= r_fill + FW'(1);
            end else if (!i_push && pop) begin
                r_fill <= r_fill - FW'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/kmer_histogram_counter.sv */
// K-mer histogram counter, top level.
// Input channel i_in_ch carries one transaction per item: mode 0 feeds one
// ASCII nucleotide (A/T/C/G either case count, N/n is skipped, other bytes
// set the error flag until mode 1 starts a new sequence), mode 2 reads the
// counter at read_index (masked to 4^K entries), mode 3 does nothing.
// Output channel o_out_ch returns exactly one transaction per input:
// kmer_count (counter on reads, else 0) and error_flag after the item.
// Throughput: one item per clock while ready is high. Each result passes
// through the table stage register and then the result queue before it is
// presented on o_out_ch; each counter update is a read-modify-write
// on a one-port-read, one-port-write memory with forwarding of the last write.
// Reset: the window, seen count and error flag clear at once; the count
// table is then swept to zero one entry a cycle, during which ready stays
// low.
// Stall: a three-entry result queue absorbs the table stage; ready drops
// only during the sweep or when the queued results plus the in-flight item fill it.
// Depends on kmc_pkg, kmc_if, kmc_front, kmc_table, kmc_out_fifo.
`timescale 1ns / 1ps
`default_nettype none

module kmer_histogram_counter #(
    parameter int K           = 4,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    kmc_in_if.sink    i_in_ch,
    kmc_out_if.source o_out_ch
);

    localparam int FW = kmc_pkg::OUT_CNT_FILL_W;

    logic                accept;
    logic                busy;
    logic                res_vld;
    kmc_pkg::t_req       req;
    kmc_pkg::t_result    res;
    logic [2*K-1:0]      addr;
    logic [FW-1:0]       fill;
    logic [FW:0]         occupancy;

    // Space check: queued results plus the one in the table stage
    assign occupancy     = {1'b0, fill} + (FW + 1)'(res_vld);
    assign i_in_ch.ready = !busy && (occupancy < (FW + 1)'(kmc_pkg::OUT_DEPTH));
    assign accept        = i_in_ch.valid && i_in_ch.ready;

    kmc_front #(
        .K (K)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_mode       (i_in_ch.mode),
        .i_symbol     (i_in_ch.symbol),
        .i_read_index (i_in_ch.read_index),
        .o_req        (req),
        .o_addr       (addr)
    );

    kmc_table #(
        .K           (K),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_req     (req),
        .i_addr    (addr),
        .o_busy    (busy),
        .o_res_vld (res_vld),
        .o_res     (res)
    );

    kmc_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (res_vld),
        .i_res    (res),
        .o_fill   (fill),
        .o_out_ch (o_out_ch)
    );

endmodule

`default_nettype wire
